FILE: src/lba2chs_pkg.sv
// shared types and constants for the lba to chs translation pipeline
// no dependencies; used by every module under src
`default_nettype none

package lba2chs_pkg;

  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned DIV_W           = 9;   // divisor and remainder width
  localparam int unsigned SPT_W           = 6;
  localparam int unsigned HEADS_W         = 9;
  localparam int unsigned CYL_W           = 16;
  localparam int unsigned HEAD_W          = 8;
  localparam int unsigned CFG_DATA_W      = 9;
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned STAGES_PER_DIV  = ADDR_W / STEPS_PER_STAGE;
  localparam int unsigned NUM_STAGES      = 2 * STAGES_PER_DIV;

  localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;
  localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd16;
  localparam logic [HEADS_W-1:0] HEADS_MAX   = 9'd256;

  typedef enum logic [0:0] {
    REG_SPT   = 1'b0,
    REG_HEADS = 1'b1
  } cfg_reg_t;

  // divisors as the pipeline sees them, zero and out-of-range values fixed up
  typedef struct packed {
    logic [DIV_W-1:0] spt_div;
    logic [DIV_W-1:0] heads_div;
  } div_cfg_t;

  // one item in flight: dividend shifting out, quotient shifting in
  typedef struct packed {
    logic [ADDR_W-1:0] num;
    logic [DIV_W-1:0]  rem;
    logic [SPT_W-1:0]  sector;
  } item_t;

endpackage

`default_nettype wire

FILE: src/lba_to_chs_translate.sv
// lba to chs translation: two pipelined dividers, address by sectors per
// track, then track index by head count, four quotient bits per stage.
// one transfer per cycle while the output is not stalled.
// each stage holds its item under output stall and bubbles close up.
// reset empties the pipeline and loads 63 sectors per track and 16 heads.
`default_nettype none

module lba_to_chs_translate (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [0:0]                          cfg_index,
  input  wire logic [lba2chs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [lba2chs_pkg::ADDR_W-1:0]      block_address,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [lba2chs_pkg::CYL_W-1:0]            cylinder,
  output logic [lba2chs_pkg::HEAD_W-1:0]           head,
  output logic [lba2chs_pkg::SPT_W-1:0]            sector,
  output logic                                     cylinder_overflow
);

  localparam int unsigned N   = lba2chs_pkg::NUM_STAGES;
  localparam int unsigned MID = lba2chs_pkg::STAGES_PER_DIV;

  lba2chs_pkg::div_cfg_t div_cfg;
  lba2chs_pkg::item_t    pipe_item  [N+1];
  logic                  pipe_valid [N+1];
  logic                  pipe_ready [N+1];
  lba2chs_pkg::item_t    mid_item;

  lba2chs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .div_cfg   (div_cfg)
  );

  assign pipe_valid[0]       = in_valid;
  assign pipe_item[0].num    = block_address;
  assign pipe_item[0].rem    = '0;
  assign pipe_item[0].sector = '0;
  assign in_stall            = !pipe_ready[0];

  // first quotient is the track index; its remainder gives the sector
  assign mid_item.num    = pipe_item[MID].num;
  assign mid_item.rem    = '0;
  assign mid_item.sector = pipe_item[MID].rem[lba2chs_pkg::SPT_W-1:0]
                           + lba2chs_pkg::SPT_W'(1);

  for (genvar k = 0; k < N; k++) begin : g_stage
    lba2chs_pkg::item_t       stage_in;
    logic [lba2chs_pkg::DIV_W-1:0] stage_div;

    if (k == MID) begin : g_mid
      assign stage_in = mid_item;
    end else begin : g_pass
      assign stage_in = pipe_item[k];
    end

    if (k < MID) begin : g_spt
      assign stage_div = div_cfg.spt_div;
    end else begin : g_heads
      assign stage_div = div_cfg.heads_div;
    end

    lba2chs_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .divisor  (stage_div),
      .up_valid (pipe_valid[k]),
      .up_item  (stage_in),
      .up_ready (pipe_ready[k]),
      .dn_valid (pipe_valid[k+1]),
      .dn_item  (pipe_item[k+1]),
      .dn_ready (pipe_ready[k+1])
    );
  end

  assign pipe_ready[N]     = !out_stall;
  assign out_valid         = pipe_valid[N];
  assign cylinder          = pipe_item[N].num[lba2chs_pkg::CYL_W-1:0];
  assign cylinder_overflow = |pipe_item[N].num[lba2chs_pkg::ADDR_W-1:lba2chs_pkg::CYL_W];
  assign head              = pipe_item[N].rem[lba2chs_pkg::HEAD_W-1:0];
  assign sector            = pipe_item[N].sector;

endmodule

`default_nettype wire

FILE: src/lba2chs_cfg.sv
// geometry registers and divisor fix-up for the lba to chs pipeline
// depends on lba2chs_pkg
`default_nettype none

module lba2chs_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [0:0]                           cfg_index,
  input  wire logic [lba2chs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lba2chs_pkg::div_cfg_t                     div_cfg
);

  logic [lba2chs_pkg::SPT_W-1:0]   spt;
  logic [lba2chs_pkg::HEADS_W-1:0] heads;

  always_ff @(posedge clk) begin
    if (rst) begin
      spt   <= lba2chs_pkg::SPT_RESET;
      heads <= lba2chs_pkg::HEADS_RESET;
    end else if (cfg_write) begin
      unique case (lba2chs_pkg::cfg_reg_t'(cfg_index))
        lba2chs_pkg::REG_SPT:   spt   <= cfg_data[lba2chs_pkg::SPT_W-1:0];
        lba2chs_pkg::REG_HEADS: heads <= cfg_data[lba2chs_pkg::HEADS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (spt == '0) begin
      div_cfg.spt_div = lba2chs_pkg::DIV_W'(1);
    end else begin
      div_cfg.spt_div = lba2chs_pkg::DIV_W'(spt);
    end
    if (heads == '0) begin
      div_cfg.heads_div = lba2chs_pkg::DIV_W'(1);
    end else if (heads > lba2chs_pkg::HEADS_MAX) begin
      div_cfg.heads_div = lba2chs_pkg::HEADS_MAX;
    end else begin
      div_cfg.heads_div = heads;
    end
  end

endmodule

`default_nettype wire

FILE: src/lba2chs_stage.sv
// one pipeline stage: STEPS_PER_STAGE restoring-division steps and a holding register
// depends on lba2chs_pkg
`default_nettype none

module lba2chs_stage (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [lba2chs_pkg::DIV_W-1:0]     divisor,
  input  wire logic                              up_valid,
  input  wire lba2chs_pkg::item_t                up_item,
  output logic                                   up_ready,
  output logic                                   dn_valid,
  output lba2chs_pkg::item_t                     dn_item,
  input  wire logic                              dn_ready
);

  lba2chs_pkg::item_t item_next;

  always_comb begin
    logic [lba2chs_pkg::DIV_W:0] trial;
    logic                        ge;
    item_next = up_item;
    for (int i = 0; i < int'(lba2chs_pkg::STEPS_PER_STAGE); i++) begin
      trial = {item_next.rem, item_next.num[lba2chs_pkg::ADDR_W-1]};
      ge    = (trial >= {1'b0, divisor});
      if (ge) begin
        trial = trial - {1'b0, divisor};
      end
      item_next.rem = trial[lba2chs_pkg::DIV_W-1:0];
      item_next.num = {item_next.num[lba2chs_pkg::ADDR_W-2:0], ge};
    end
  end

  // register empties or moves on in the same cycle
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule

`default_nettype wire
